/* design/rpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reflector pair detector package
// Shared widths, reset values and register indexes of the pair detector.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF = 10;

   localparam int MIN_POINTS_W = 10;
   localparam int GAP_W        = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   // per-axis gap magnitude limit is 2^GAP_AXIS_BITS
   localparam int GAP_AXIS_BITS = 16;
   localparam int GAP_SQ_W      = 2 * GAP_AXIS_BITS;
   localparam int GAP_SUM_W     = GAP_SQ_W + 2;

   localparam logic [MIN_POINTS_W-1:0] MIN_POINTS_RST = MIN_POINTS_W'(5);
   localparam logic [GAP_W-1:0]        GAP_MIN_RST    = GAP_W'(380);
   localparam logic [GAP_W-1:0]        GAP_MAX_RST    = GAP_W'(410);

   localparam logic [GAP_SQ_W-1:0] GAP_MIN_SQ_RST = GAP_SQ_W'(380 * 380);
   localparam logic [GAP_SQ_W-1:0] GAP_MAX_SQ_RST = GAP_SQ_W'(410 * 410);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_POINTS = 2'd0,
      CSR_GAP_MIN    = 2'd1,
      CSR_GAP_MAX    = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

/* design/reflector_pair_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reflector pair detector
// The result of a scan_end item is registered as the item leaves the input
// register. Throughput: one item per cycle; a scan_end item waits in the input
// register only while an earlier result is still held on the result channel.
// The gap squares are taken when a segment opens, so closing a segment needs
// only a three-term add and two compares.
// Reset: synchronous, clears scan state and loads default thresholds.
// ----------------------------------------------------------------------------
module reflector_pair_detector #(
   parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = rpd_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic signed [COORD_BITS-1:0]        req_px,
   input  wire logic signed [COORD_BITS-1:0]        req_py,
   input  wire logic signed [COORD_BITS-1:0]        req_pz,
   input  wire logic                                req_reflective,
   input  wire logic                                req_scan_end,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic                                rsp_found,
   output      logic signed [COORD_BITS-1:0]        rsp_start_x,
   output      logic signed [COORD_BITS-1:0]        rsp_start_y,
   output      logic signed [COORD_BITS-1:0]        rsp_start_z,
   output      logic signed [COORD_BITS-1:0]        rsp_mid_x,
   output      logic signed [COORD_BITS-1:0]        rsp_mid_y,
   output      logic signed [COORD_BITS-1:0]        rsp_mid_z,
   output      logic signed [COORD_BITS-1:0]        rsp_end_x,
   output      logic signed [COORD_BITS-1:0]        rsp_end_y,
   output      logic signed [COORD_BITS-1:0]        rsp_end_z,
   input  wire logic                                csr_we,
   input  wire logic [rpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rpd_pkg::*;

   localparam int MAG_W = (COORD_BITS > GAP_AXIS_BITS) ? COORD_BITS : GAP_AXIS_BITS;
   localparam int CMP_W = (COUNT_BITS > MIN_POINTS_W) ? COUNT_BITS : MIN_POINTS_W;

   // configuration
   logic [MIN_POINTS_W-1:0] min_points_ff;
   logic [GAP_SQ_W-1:0]     gap_lo_sq_ff;
   logic [GAP_SQ_W-1:0]     gap_hi_sq_ff;

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic signed [COORD_BITS-1:0] in_p_ff [3];
   logic                         in_refl_ff;
   logic                         in_end_ff;

   // scan state
   logic [COUNT_BITS-1:0]        cur_count_ff, cur_count_in;
   logic signed [COORD_BITS-1:0] cur_first_ff [3];
   logic signed [COORD_BITS-1:0] cur_last_ff [3];
   logic                         prev_valid_ff, prev_valid_in;
   logic                         prev_big_ff, prev_big_in;
   logic signed [COORD_BITS-1:0] prev_first_ff [3];
   logic signed [COORD_BITS-1:0] prev_last_ff [3];
   logic                         match_latched_ff, match_latched_in;
   logic signed [COORD_BITS-1:0] match_start_ff [3];
   logic signed [COORD_BITS-1:0] match_mid_ff [3];
   logic signed [COORD_BITS-1:0] match_end_ff [3];
   logic [GAP_SQ_W-1:0]          gap_sq_ff [3];
   logic                         gap_far_ff;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic signed [COORD_BITS-1:0] rsp_start_ff [3];
   logic signed [COORD_BITS-1:0] rsp_mid_ff [3];
   logic signed [COORD_BITS-1:0] rsp_end_ff [3];

   // combinational
   logic                         req_fire;
   logic                         out_free;
   logic                         advance;
   logic                         seg_start;
   logic                         seg_close;
   logic                         seg_big;
   logic                         gap_ok;
   logic                         pair_hit;
   logic                         found_in;
   logic [GAP_SUM_W-1:0]         gap_sum;
   logic signed [COORD_BITS:0]   diff [3];
   logic [COORD_BITS:0]          mag_full [3];
   logic [MAG_W-1:0]             mag [3];
   logic [GAP_SQ_W-1:0]          sq_in [3];
   logic [2:0]                   far_axis;
   logic [COORD_BITS:0]          mid_sum [3];
   logic signed [COORD_BITS-1:0] mid_in [3];
   logic signed [COORD_BITS-1:0] sel_start [3];
   logic signed [COORD_BITS-1:0] sel_mid [3];
   logic signed [COORD_BITS-1:0] sel_end [3];

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_end_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign seg_start = in_refl_ff && (cur_count_ff == '0);
   assign seg_close = !in_refl_ff && (cur_count_ff != '0);
   assign seg_big   = CMP_W'(cur_count_ff) > CMP_W'(min_points_ff);

   assign gap_sum = GAP_SUM_W'(gap_sq_ff[0]) + GAP_SUM_W'(gap_sq_ff[1])
                  + GAP_SUM_W'(gap_sq_ff[2]);
   assign gap_ok  = !gap_far_ff && (gap_sum > GAP_SUM_W'(gap_lo_sq_ff))
                  && (gap_sum < GAP_SUM_W'(gap_hi_sq_ff));

   assign pair_hit = seg_close && !match_latched_ff && prev_valid_ff && prev_big_ff
                   && seg_big && gap_ok;
   assign found_in = match_latched_ff || pair_hit;

   // gap from the earlier segment's last point to the opening point
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]     = {prev_last_ff[i][COORD_BITS-1], prev_last_ff[i]}
                     - {in_p_ff[i][COORD_BITS-1], in_p_ff[i]};
         mag_full[i] = diff[i][COORD_BITS] ? (COORD_BITS+1)'(-diff[i])
                                           : (COORD_BITS+1)'(diff[i]);
         mag[i]      = MAG_W'(mag_full[i][COORD_BITS-1:0]);
         far_axis[i] = (mag[i] >> GAP_AXIS_BITS) != '0;
         sq_in[i]    = GAP_SQ_W'(mag[i][GAP_AXIS_BITS-1:0])
                     * GAP_SQ_W'(mag[i][GAP_AXIS_BITS-1:0]);
         mid_sum[i]  = {prev_last_ff[i][COORD_BITS-1], prev_last_ff[i]}
                     + {cur_first_ff[i][COORD_BITS-1], cur_first_ff[i]};
         mid_in[i]   = mid_sum[i][COORD_BITS:1];
         sel_start[i] = pair_hit ? prev_first_ff[i] : match_start_ff[i];
         sel_mid[i]   = pair_hit ? mid_in[i] : match_mid_ff[i];
         sel_end[i]   = pair_hit ? cur_last_ff[i] : match_end_ff[i];
      end
   end

   always_comb begin
      in_valid_in      = in_valid_ff;
      cur_count_in     = cur_count_ff;
      prev_valid_in    = prev_valid_ff;
      prev_big_in      = prev_big_ff;
      match_latched_in = match_latched_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         in_valid_in = 1'b0;
         if (in_refl_ff) begin
            if (cur_count_ff != '1) begin
               cur_count_in = cur_count_ff + COUNT_BITS'(1);
            end
         end else if (seg_close) begin
            cur_count_in  = '0;
            prev_valid_in = 1'b1;
            prev_big_in   = seg_big;
         end
         if (pair_hit) begin
            match_latched_in = 1'b1;
         end
         if (in_end_ff) begin
            cur_count_in     = '0;
            prev_valid_in    = 1'b0;
            prev_big_in      = 1'b0;
            match_latched_in = 1'b0;
            rsp_valid_in     = 1'b1;
         end
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_points_ff    <= MIN_POINTS_RST;
         gap_lo_sq_ff     <= GAP_MIN_SQ_RST;
         gap_hi_sq_ff     <= GAP_MAX_SQ_RST;
         in_valid_ff      <= 1'b0;
         cur_count_ff     <= '0;
         prev_valid_ff    <= 1'b0;
         prev_big_ff      <= 1'b0;
         match_latched_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         cur_count_ff     <= cur_count_in;
         prev_valid_ff    <= prev_valid_in;
         prev_big_ff      <= prev_big_in;
         match_latched_ff <= match_latched_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MIN_POINTS: begin
                  min_points_ff <= csr_wdata[MIN_POINTS_W-1:0];
               end
               CSR_GAP_MIN: begin
                  gap_lo_sq_ff <= GAP_SQ_W'(csr_wdata[GAP_W-1:0])
                                * GAP_SQ_W'(csr_wdata[GAP_W-1:0]);
               end
               CSR_GAP_MAX: begin
                  gap_hi_sq_ff <= GAP_SQ_W'(csr_wdata[GAP_W-1:0])
                                * GAP_SQ_W'(csr_wdata[GAP_W-1:0]);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_p_ff[0] <= req_px;
         in_p_ff[1] <= req_py;
         in_p_ff[2] <= req_pz;
         in_refl_ff <= req_reflective;
         in_end_ff  <= req_scan_end;
      end
      if (advance && seg_start) begin
         cur_first_ff <= in_p_ff;
         gap_sq_ff    <= sq_in;
         gap_far_ff   <= |far_axis;
      end
      if (advance && in_refl_ff) begin
         cur_last_ff <= in_p_ff;
      end
      if (advance && seg_close) begin
         prev_first_ff <= cur_first_ff;
         prev_last_ff  <= cur_last_ff;
      end
      if (advance && pair_hit) begin
         match_start_ff <= prev_first_ff;
         match_mid_ff   <= mid_in;
         match_end_ff   <= cur_last_ff;
      end
      if (advance && in_end_ff) begin
         rsp_found_ff <= found_in;
         for (int i = 0; i < 3; i++) begin
            rsp_start_ff[i] <= found_in ? sel_start[i] : '0;
            rsp_mid_ff[i]   <= found_in ? sel_mid[i] : '0;
            rsp_end_ff[i]   <= found_in ? sel_end[i] : '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_start_x = rsp_start_ff[0];
   assign rsp_start_y = rsp_start_ff[1];
   assign rsp_start_z = rsp_start_ff[2];
   assign rsp_mid_x   = rsp_mid_ff[0];
   assign rsp_mid_y   = rsp_mid_ff[1];
   assign rsp_mid_z   = rsp_mid_ff[2];
   assign rsp_end_x   = rsp_end_ff[0];
   assign rsp_end_y   = rsp_end_ff[1];
   assign rsp_end_z   = rsp_end_ff[2];

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_end_ff |=> rsp_valid_ff)
      else $error("scan end item produced no result");

   a_end_clears_scan: assert property (@(posedge clock) disable iff (reset)
      advance && in_end_ff |=> cur_count_ff == '0 && !match_latched_ff && !prev_valid_ff)
      else $error("scan state not cleared at scan end");

   a_match_holds: assert property (@(posedge clock) disable iff (reset)
      match_latched_ff && !(advance && in_end_ff) |=> match_latched_ff)
      else $error("latched match lost within scan");

   a_big_needs_prev: assert property (@(posedge clock) disable iff (reset)
      prev_big_ff |-> prev_valid_ff)
      else $error("previous segment size flag without a previous segment");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_start_ff[0] == '0 && rsp_mid_ff[1] == '0
                                         && rsp_end_ff[2] == '0)
      else $error("result without match carries coordinates");

endmodule
`default_nettype wire

/* tb/rpd_pair_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reflector pair detector checker
// Watches the point and report channels and the register port, keeps its own
// copy of the segment tracking and thresholds, predicts the report of every
// scan and compares each accepted report field by field with the oldest one.
// ----------------------------------------------------------------------------
module rpd_pair_checker #(
   parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = rpd_pkg::COUNT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic signed [COORD_BITS-1:0]    req_px,
   input  wire logic signed [COORD_BITS-1:0]    req_py,
   input  wire logic signed [COORD_BITS-1:0]    req_pz,
   input  wire logic                            req_reflective,
   input  wire logic                            req_scan_end,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic                            rsp_found,
   input  wire logic signed [COORD_BITS-1:0]    rsp_start_x,
   input  wire logic signed [COORD_BITS-1:0]    rsp_start_y,
   input  wire logic signed [COORD_BITS-1:0]    rsp_start_z,
   input  wire logic signed [COORD_BITS-1:0]    rsp_mid_x,
   input  wire logic signed [COORD_BITS-1:0]    rsp_mid_y,
   input  wire logic signed [COORD_BITS-1:0]    rsp_mid_z,
   input  wire logic signed [COORD_BITS-1:0]    rsp_end_x,
   input  wire logic signed [COORD_BITS-1:0]    rsp_end_y,
   input  wire logic signed [COORD_BITS-1:0]    rsp_end_z,
   input  wire logic                            csr_we,
   input  wire logic [rpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rpd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                   fail_count,
   output int                                   pairs_due
);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      logic      found;
      point_type start_p;
      point_type mid_p;
      point_type end_p;
   } pair_report_type;

   pair_report_type pair_reports[$];

   logic [rpd_pkg::MIN_POINTS_W-1:0] min_pts;
   logic [rpd_pkg::GAP_W-1:0]        gap_lo;
   logic [rpd_pkg::GAP_W-1:0]        gap_hi;

   logic [COUNT_BITS-1:0] seg_count;
   point_type             seg_first;
   point_type             seg_last;
   bit                    have_prev;
   bit                    prev_big;
   point_type             prev_first;
   point_type             prev_last;
   bit                    pair_held;
   point_type             pair_start;
   point_type             pair_mid;
   point_type             pair_end;

   function automatic longint axis_of(point_type p, int i);
      case (i)
         0: return longint'($signed(p.x));
         1: return longint'($signed(p.y));
         default: return longint'($signed(p.z));
      endcase
   endfunction

   function automatic bit gap_in_range(point_type a, point_type b);
      longint lo;
      longint hi;
      longint d;
      longint sum;
      lo  = longint'(gap_lo) * longint'(gap_lo);
      hi  = longint'(gap_hi) * longint'(gap_hi);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         d = axis_of(a, i) - axis_of(b, i);
         if (d < 0) d = -d;
         if (d >= 65536) return 1'b0;
         sum += d * d;
      end
      return (sum > lo) && (sum < hi);
   endfunction

   function automatic point_type gap_midpoint(point_type a, point_type b);
      point_type m;
      m.x = coord_type'((axis_of(a, 0) + axis_of(b, 0)) >>> 1);
      m.y = coord_type'((axis_of(a, 1) + axis_of(b, 1)) >>> 1);
      m.z = coord_type'((axis_of(a, 2) + axis_of(b, 2)) >>> 1);
      return m;
   endfunction

   function automatic void clear_scan();
      seg_count  = '0;
      seg_first  = '0;
      seg_last   = '0;
      have_prev  = 1'b0;
      prev_big   = 1'b0;
      prev_first = '0;
      prev_last  = '0;
      pair_held  = 1'b0;
      pair_start = '0;
      pair_mid   = '0;
      pair_end   = '0;
   endfunction

   function automatic void close_segment();
      bit big;
      big = seg_count > min_pts;
      if (!pair_held && have_prev && prev_big && big && gap_in_range(prev_last, seg_first)) begin
         pair_held  = 1'b1;
         pair_start = prev_first;
         pair_mid   = gap_midpoint(prev_last, seg_first);
         pair_end   = seg_last;
      end
      have_prev  = 1'b1;
      prev_big   = big;
      prev_first = seg_first;
      prev_last  = seg_last;
      seg_count  = '0;
   endfunction

   function automatic void take_point(point_type p, logic refl, logic last);
      if (refl) begin
         if (seg_count == 0) seg_first = p;
         seg_last = p;
         if (seg_count != '1) seg_count++;
      end else if (seg_count != 0) begin
         close_segment();
      end
      if (last) begin
         pair_reports.insert(pair_reports.size(),
                             pair_report_type'{pair_held, pair_start, pair_mid, pair_end});
         clear_scan();
      end
   endfunction

   function automatic void check_axis(string name, coord_type want, coord_type seen);
      if (seen !== want) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         fail_count++;
      end
   endfunction

   function automatic void check_report(pair_report_type seen);
      pair_report_type want;
      want = pair_reports.pop_front();
      if (seen.found !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, seen.found);
         fail_count++;
      end
      check_axis("start_x", want.start_p.x, seen.start_p.x);
      check_axis("start_y", want.start_p.y, seen.start_p.y);
      check_axis("start_z", want.start_p.z, seen.start_p.z);
      check_axis("mid_x", want.mid_p.x, seen.mid_p.x);
      check_axis("mid_y", want.mid_p.y, seen.mid_p.y);
      check_axis("mid_z", want.mid_p.z, seen.mid_p.z);
      check_axis("end_x", want.end_p.x, seen.end_p.x);
      check_axis("end_y", want.end_p.y, seen.end_p.y);
      check_axis("end_z", want.end_p.z, seen.end_p.z);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         min_pts = rpd_pkg::MIN_POINTS_RST;
         gap_lo  = rpd_pkg::GAP_MIN_RST;
         gap_hi  = rpd_pkg::GAP_MAX_RST;
         clear_scan();
         pair_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pair_reports.size() == 0) begin
               $error("report with no scan end waiting: found %0d", rsp_found);
               fail_count++;
            end else begin
               check_report({rsp_found,
                             rsp_start_x, rsp_start_y, rsp_start_z,
                             rsp_mid_x, rsp_mid_y, rsp_mid_z,
                             rsp_end_x, rsp_end_y, rsp_end_z});
            end
         end
         if (req_valid && req_ready)
            take_point({req_px, req_py, req_pz}, req_reflective, req_scan_end);
         if (csr_we) begin
            case (csr_index)
               rpd_pkg::CSR_MIN_POINTS: min_pts = csr_wdata[rpd_pkg::MIN_POINTS_W-1:0];
               rpd_pkg::CSR_GAP_MIN:    gap_lo  = csr_wdata[rpd_pkg::GAP_W-1:0];
               rpd_pkg::CSR_GAP_MAX:    gap_hi  = csr_wdata[rpd_pkg::GAP_W-1:0];
               default: ;
            endcase
         end
      end
      pairs_due = pair_reports.size();
   end

endmodule

/* tb/reflector_pair_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reflector pair detector testbench
// Streams laser scans into the detector: a few hand-built scans first, then
// random scans made of reflector segments with gaps placed inside and outside
// the thresholds, plus noise scans, across several threshold settings. Both
// channels stall at random; the checker beside the block judges every report.
// ----------------------------------------------------------------------------
module reflector_pair_detector_tb;

   localparam int CW = rpd_pkg::COORD_BITS_DEF;
   localparam logic [rpd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int POINT_TARGET = 1000;
   localparam int PHASE_POINTS = 120;

   typedef logic signed [CW-1:0] coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid      = 1'b0;
   logic      req_ready;
   coord_type req_px         = '0;
   coord_type req_py         = '0;
   coord_type req_pz         = '0;
   logic      req_reflective = 1'b0;
   logic      req_scan_end   = 1'b0;

   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_found;
   coord_type rsp_start_x, rsp_start_y, rsp_start_z;
   coord_type rsp_mid_x, rsp_mid_y, rsp_mid_z;
   coord_type rsp_end_x, rsp_end_y, rsp_end_z;

   logic                            csr_we    = 1'b0;
   logic [rpd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rpd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int pairs_due;
   bit calm = 1'b0;
   int thr_min = 5;
   int thr_lo  = 380;
   int thr_hi  = 410;
   int point_total = 0;

   always #2 clock = ~clock;

   reflector_pair_detector u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_px         (req_px),
      .req_py         (req_py),
      .req_pz         (req_pz),
      .req_reflective (req_reflective),
      .req_scan_end   (req_scan_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_start_x    (rsp_start_x),
      .rsp_start_y    (rsp_start_y),
      .rsp_start_z    (rsp_start_z),
      .rsp_mid_x      (rsp_mid_x),
      .rsp_mid_y      (rsp_mid_y),
      .rsp_mid_z      (rsp_mid_z),
      .rsp_end_x      (rsp_end_x),
      .rsp_end_y      (rsp_end_y),
      .rsp_end_z      (rsp_end_z),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   rpd_pair_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_px         (req_px),
      .req_py         (req_py),
      .req_pz         (req_pz),
      .req_reflective (req_reflective),
      .req_scan_end   (req_scan_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_start_x    (rsp_start_x),
      .rsp_start_y    (rsp_start_y),
      .rsp_start_z    (rsp_start_z),
      .rsp_mid_x      (rsp_mid_x),
      .rsp_mid_y      (rsp_mid_y),
      .rsp_mid_z      (rsp_mid_z),
      .rsp_end_x      (rsp_end_x),
      .rsp_end_y      (rsp_end_y),
      .rsp_end_z      (rsp_end_z),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pairs_due      (pairs_due)
   );

   always @(negedge clock) begin
      if (calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 15);
   end

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type near_coord();
      return coord_type'(int'($urandom_range(40000)) - 20000);
   endfunction

   task automatic send_point(coord_type x, coord_type y, coord_type z, logic refl, logic last);
      if (!calm) begin
         while ($urandom_range(99) < 15) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_px         <= x;
      req_py         <= y;
      req_pz         <= z;
      req_reflective <= refl;
      req_scan_end   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      point_total++;
      @(negedge clock);
   endtask

   // hold the stream until every report is in, then let the pipe empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pairs_due != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_thresholds(int mp, int lo, int hi);
      wait_drained();
      thr_min = mp;
      thr_lo  = lo;
      thr_hi  = hi;
      csr_we    <= 1'b1;
      csr_index <= rpd_pkg::CSR_MIN_POINTS;
      csr_wdata <= {6'($urandom_range(63)), 10'(mp)};
      @(negedge clock);
      csr_index <= rpd_pkg::CSR_GAP_MIN;
      csr_wdata <= rpd_pkg::CSR_DATA_W'(lo);
      @(negedge clock);
      csr_index <= rpd_pkg::CSR_GAP_MAX;
      csr_wdata <= rpd_pkg::CSR_DATA_W'(hi);
      @(negedge clock);
      csr_index <= CSR_SPARE_INDEX;
      csr_wdata <= rpd_pkg::CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic pick_gap(output int dx, output int dy, output int dz);
      longint lo;
      longint hi;
      longint d2;
      int     g;
      lo = longint'(thr_lo) * thr_lo;
      hi = longint'(thr_hi) * thr_hi;
      g  = (thr_hi > 0) ? thr_hi : 1;
      for (int k = 0; k < 40; k++) begin
         dx = int'($urandom_range(2 * g)) - g;
         dy = int'($urandom_range(2 * g)) - g;
         dz = int'($urandom_range(2 * g)) - g;
         d2 = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
         if (d2 > lo && d2 < hi) return;
      end
      dx = (thr_lo + thr_hi) / 2;
      dy = 0;
      dz = 0;
   endtask

   function automatic int seg_len();
      if (thr_min > 8) return $urandom_range(1, 8);
      return (thr_min == 0) ? $urandom_range(1, 3) : thr_min - 1 + $urandom_range(4);
   endfunction

   task automatic send_segment(int n, coord_type fx, coord_type fy, coord_type fz,
                               output coord_type lx, output coord_type ly,
                               output coord_type lz);
      lx = (n == 1) ? fx : near_coord();
      ly = (n == 1) ? fy : near_coord();
      lz = (n == 1) ? fz : near_coord();
      send_point(fx, fy, fz, 1'b1, 1'b0);
      for (int k = 1; k < n; k++) begin
         if (k == n - 1) send_point(lx, ly, lz, 1'b1, 1'b0);
         else send_point(any_coord(), any_coord(), any_coord(), 1'b1, 1'b0);
      end
   endtask

   task automatic send_reflector_scan();
      int        nseg;
      int        dx, dy, dz;
      coord_type fx, fy, fz;
      coord_type lx, ly, lz;
      repeat ($urandom_range(3)) send_point(any_coord(), any_coord(), any_coord(), 1'b0, 1'b0);
      nseg = $urandom_range(1, 4);
      fx = near_coord();
      fy = near_coord();
      fz = near_coord();
      for (int s = 0; s < nseg; s++) begin
         send_segment(seg_len(), fx, fy, fz, lx, ly, lz);
         if (s != nseg - 1) begin
            repeat ($urandom_range(1, 3))
               send_point(any_coord(), any_coord(), any_coord(), 1'b0, 1'b0);
            if ($urandom_range(99) < 80) begin
               pick_gap(dx, dy, dz);
               fx = coord_type'(lx + dx);
               fy = coord_type'(ly + dy);
               fz = coord_type'(lz + dz);
            end else begin
               fx = near_coord();
               fy = near_coord();
               fz = near_coord();
            end
         end
      end
      case ($urandom_range(2))
         0: send_point(any_coord(), any_coord(), any_coord(), 1'b0, 1'b1);
         1: send_point(any_coord(), any_coord(), any_coord(), 1'b1, 1'b1);
         default: begin
            send_point(any_coord(), any_coord(), any_coord(), 1'b0, 1'b0);
            send_point(any_coord(), any_coord(), any_coord(), 1'b0, 1'b1);
         end
      endcase
   endtask

   task automatic send_noise_scan();
      repeat ($urandom_range(12))
         send_point(any_coord(), any_coord(), any_coord(), 1'($urandom), 1'b0);
      send_point(any_coord(), any_coord(), any_coord(), 1'($urandom), 1'b1);
   endtask

   task automatic directed_scans();
      // matching pair with an odd negative gap sum
      repeat (5) send_point(near_coord(), near_coord(), near_coord(), 1'b1, 1'b0);
      send_point(-16'sd1001, -16'sd3, 16'sd0, 1'b1, 1'b0);
      send_point(any_coord(), any_coord(), any_coord(), 1'b0, 1'b0);
      send_point(-16'sd602, -16'sd2, 16'sd1, 1'b1, 1'b0);
      repeat (5) send_point(near_coord(), near_coord(), near_coord(), 1'b1, 1'b0);
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
      // extremes, scan end on an open segment
      send_point(16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
      send_point(-16'sh8000, 16'sh7FFF, -16'sh8000, 1'b1, 1'b0);
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
      send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1, 1'b1);
      // lone scan end
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);
   endtask

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int phase;
      int phase_start;
      int lo;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_scans();
      phase = 1;
      while (point_total < POINT_TARGET) begin
         case (phase)
            1: set_thresholds(0, 0, 65535);
            2: set_thresholds(3, 410, 380);
            3: set_thresholds(2, 500, 500);
            4: set_thresholds(1022, 380, 410);
            5: set_thresholds(1023, 0, 65535);
            default: begin
               lo = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1000);
               if ($urandom_range(9) == 0)
                  set_thresholds($urandom_range(6), lo, $urandom_range(65535));
               else
                  set_thresholds($urandom_range(6), lo,
                                 (lo + 300 > 65535) ? 65535 : lo + $urandom_range(1, 300));
            end
         endcase
         calm <= (phase == 6);
         phase_start = point_total;
         while (point_total - phase_start < PHASE_POINTS) begin
            if ($urandom_range(99) < 70) send_reflector_scan();
            else send_noise_scan();
         end
         phase++;
      end
      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
